// File: hw/rtl/vbo_pkg.sv
package vbo_pkg;

    localparam int AXIS_BITS = 5;
    localparam int ADDR_W    = 3 * AXIS_BITS;
    localparam int DEPTH     = 1 << ADDR_W;
    localparam int HALF      = 1 << (AXIS_BITS - 1);
    localparam int COORD_W   = 24;
    localparam int PROB_W    = 16;
    localparam int VSIZE_W   = 23;
    localparam int ENTRY_W   = 1 + 2 + PROB_W;
    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = 2;

    typedef enum logic [1:0] {
        CLASS_FREE     = 2'd0,
        CLASS_UNKNOWN  = 2'd1,
        CLASS_OCCUPIED = 2'd2
    } class_t;

    typedef enum logic [1:0] {
        REG_OCC_THR  = 2'd0,
        REG_FREE_THR = 2'd1,
        REG_VSIZE    = 2'd2,
        REG_INIT_P   = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV,
        F_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        B_CLEAR,
        B_IDLE,
        B_READ,
        B_MUL,
        B_SUM,
        B_DIV,
        B_OUT
    } back_state_t;

    // one classified item between front and back
    typedef struct packed {
        logic              in_grid;
        logic [ADDR_W-1:0] addr;
        logic [PROB_W-1:0] obs;
    } job_t;

    typedef struct packed {
        logic [PROB_W-1:0] occ_thr;
        logic [PROB_W-1:0] free_thr;
        logic [PROB_W-1:0] init_p;
    } back_cfg_t;

    function automatic class_t classify(input logic [PROB_W-1:0] p,
                                        input logic [PROB_W-1:0] occ_thr,
                                        input logic [PROB_W-1:0] free_thr);
        class_t c;
        if (p > occ_thr)
            c = CLASS_OCCUPIED;
        else if (p < free_thr)
            c = CLASS_FREE;
        else
            c = CLASS_UNKNOWN;
        return c;
    endfunction

endpackage

// File: hw/rtl/vbo_ram.sv
module vbo_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// File: hw/rtl/vbo_front.sv
module vbo_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            enable,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [vbo_pkg::COORD_W-1:0]     px,
    input  logic [vbo_pkg::COORD_W-1:0]     py,
    input  logic [vbo_pkg::COORD_W-1:0]     pz,
    input  logic [vbo_pkg::PROB_W-1:0]      obs,
    input  logic [vbo_pkg::VSIZE_W-1:0]     vsize,
    output logic                            push,
    output vbo_pkg::job_t                   job,
    input  logic                            full
);
    import vbo_pkg::*;

    front_state_t state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;
    logic [COORD_W-1:0] dvd_reg [3];
    logic [COORD_W-1:0] rem_reg [3];
    logic [COORD_W-1:0] dvd_next [3];
    logic [COORD_W-1:0] rem_next [3];
    logic [2:0] neg_reg, neg_next;
    logic [PROB_W-1:0] obs_reg, obs_next;
    logic vzero_reg, vzero_next;
    logic [COORD_W-1:0] coord [3];
    logic [2:0] ax_in;
    logic [AXIS_BITS-1:0] ax_addr [3];

    assign coord[0] = px;
    assign coord[1] = py;
    assign coord[2] = pz;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg   <= cnt_next;
        dvd_reg   <= dvd_next;
        rem_reg   <= rem_next;
        neg_reg   <= neg_next;
        obs_reg   <= obs_next;
        vzero_reg <= vzero_next;
    end

    // range check and per-axis address from the finished quotients
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            if (neg_reg[a])
            begin
                ax_in[a]   = dvd_reg[a] <= COORD_W'(HALF);
                ax_addr[a] = AXIS_BITS'(HALF) - dvd_reg[a][AXIS_BITS-1:0];
            end
            else
            begin
                ax_in[a]   = dvd_reg[a] <= COORD_W'(HALF - 1);
                ax_addr[a] = AXIS_BITS'(HALF) + dvd_reg[a][AXIS_BITS-1:0];
            end
        end
    end

    assign job.in_grid = !vzero_reg && (&ax_in);
    assign job.addr    = {ax_addr[2], ax_addr[1], ax_addr[0]};
    assign job.obs     = obs_reg;

    always_comb
    begin
        logic [COORD_W-1:0] mag;
        logic [COORD_W-1:0] rsh;
        state_next = state_reg;
        cnt_next   = cnt_reg;
        dvd_next   = dvd_reg;
        rem_next   = rem_reg;
        neg_next   = neg_reg;
        obs_next   = obs_reg;
        vzero_next = vzero_reg;
        in_ready   = 1'b0;
        push       = 1'b0;
        mag        = '0;
        rsh        = '0;
        case (state_reg)
            F_IDLE:
            begin
                in_ready = enable;
                if (enable && in_valid)
                begin
                    for (int a = 0; a < 3; a++)
                    begin
                        neg_next[a] = coord[a][COORD_W-1];
                        mag = neg_next[a] ? (~coord[a] + 1'b1) : coord[a];
                        // floor for negatives: round the magnitude up
                        dvd_next[a] = neg_next[a] ? mag + COORD_W'(vsize) - 1'b1 : mag;
                        rem_next[a] = '0;
                    end
                    obs_next   = obs;
                    vzero_next = vsize == '0;
                    cnt_next   = '0;
                    state_next = F_DIV;
                end
            end
            F_DIV:
            begin
                for (int a = 0; a < 3; a++)
                begin
                    rsh = {rem_reg[a][COORD_W-2:0], dvd_reg[a][COORD_W-1]};
                    if (rsh >= COORD_W'(vsize))
                    begin
                        rem_next[a] = rsh - COORD_W'(vsize);
                        dvd_next[a] = {dvd_reg[a][COORD_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next[a] = rsh;
                        dvd_next[a] = {dvd_reg[a][COORD_W-2:0], 1'b0};
                    end
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 5'(COORD_W - 1))
                begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (!full)
                begin
                    push       = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end
endmodule

// File: hw/rtl/vbo_queue.sv
module vbo_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  vbo_pkg::job_t wdata,
    output logic          full,
    input  logic          pop,
    output vbo_pkg::job_t rdata,
    output logic          empty
);
    import vbo_pkg::*;

    job_t slot_reg [QDEPTH];
    logic [QPTR_W-1:0] wp_reg, rp_reg;
    logic [QPTR_W:0] cnt_reg;

    assign full  = cnt_reg == (QPTR_W+1)'(QDEPTH);
    assign empty = cnt_reg == '0;
    assign rdata = slot_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (pop && !empty)
            begin
                rp_reg <= rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (QPTR_W+1)'(push && !full) - (QPTR_W+1)'(pop && !empty);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            slot_reg[wp_reg] <= wdata;
        end
    end
endmodule

// File: hw/rtl/vbo_back.sv
module vbo_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  vbo_pkg::back_cfg_t          cfg,
    input  logic                        empty,
    input  vbo_pkg::job_t               job,
    output logic                        pop,
    output logic                        ready_for_items,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [1:0]                  out_class,
    output logic [vbo_pkg::PROB_W-1:0]  out_prob,
    output logic                        out_changed,
    output logic                        out_new,
    output logic                        out_oor,
    output logic                        out_inv
);
    import vbo_pkg::*;

    back_state_t state_reg, state_next;
    logic [ADDR_W-1:0] clr_reg, clr_next;
    job_t cur_reg, cur_next;
    logic [PROB_W-1:0] p_reg, p_next;
    class_t old_reg, old_next;
    logic [31:0] num_reg, num_next;
    logic [33:0] prod_reg, prod_next;
    logic [33:0] den_reg, den_next;
    logic [33:0] rem_reg, rem_next;
    logic [16:0] q_reg, q_next;
    logic [16:0] xlo_reg, xlo_next;
    logic [4:0] cnt_reg, cnt_next;
    logic wr_reg, wr_next;
    class_t rcls_reg, rcls_next;
    logic [PROB_W-1:0] rprob_reg, rprob_next;
    logic rchg_reg, rchg_next, rnew_reg, rnew_next, roor_reg, roor_next;
    logic rinv_reg, rinv_next;
    logic ov_reg, ov_next;
    class_t ocls_reg, ocls_next;
    logic [PROB_W-1:0] oprob_reg, oprob_next;
    logic ochg_reg, ochg_next, onew_reg, onew_next, ooor_reg, ooor_next;
    logic oinv_reg, oinv_next;

    logic ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

    vbo_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (job.addr),
        .rdata (ram_rdata)
    );

    assign ready_for_items = state_reg != B_CLEAR;
    assign out_valid   = ov_reg;
    assign out_class   = ocls_reg;
    assign out_prob    = oprob_reg;
    assign out_changed = ochg_reg;
    assign out_new     = onew_reg;
    assign out_oor     = ooor_reg;
    assign out_inv     = oinv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_CLEAR;
            clr_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        p_reg     <= p_next;
        old_reg   <= old_next;
        num_reg   <= num_next;
        prod_reg  <= prod_next;
        den_reg   <= den_next;
        rem_reg   <= rem_next;
        q_reg     <= q_next;
        xlo_reg   <= xlo_next;
        cnt_reg   <= cnt_next;
        wr_reg    <= wr_next;
        rcls_reg  <= rcls_next;
        rprob_reg <= rprob_next;
        rchg_reg  <= rchg_next;
        rnew_reg  <= rnew_next;
        roor_reg  <= roor_next;
        rinv_reg  <= rinv_next;
        ocls_reg  <= ocls_next;
        oprob_reg <= oprob_next;
        ochg_reg  <= ochg_next;
        onew_reg  <= onew_next;
        ooor_reg  <= ooor_next;
        oinv_reg  <= oinv_next;
    end

    always_comb
    begin
        logic [48:0] x;
        logic [33:0] rsh;
        logic [PROB_W-1:0] qs;
        class_t nc;
        state_next = state_reg;
        clr_next   = clr_reg;
        cur_next   = cur_reg;
        p_next     = p_reg;
        old_next   = old_reg;
        num_next   = num_reg;
        prod_next  = prod_reg;
        den_next   = den_reg;
        rem_next   = rem_reg;
        q_next     = q_reg;
        xlo_next   = xlo_reg;
        cnt_next   = cnt_reg;
        wr_next    = wr_reg;
        rcls_next  = rcls_reg;
        rprob_next = rprob_reg;
        rchg_next  = rchg_reg;
        rnew_next  = rnew_reg;
        roor_next  = roor_reg;
        rinv_next  = rinv_reg;
        ov_next    = ov_reg && !out_ready;
        ocls_next  = ocls_reg;
        oprob_next = oprob_reg;
        ochg_next  = ochg_reg;
        onew_next  = onew_reg;
        ooor_next  = ooor_reg;
        oinv_next  = oinv_reg;
        pop        = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = cur_reg.addr;
        ram_wdata  = {1'b1, rcls_reg, rprob_reg};
        x   = '0;
        rsh = '0;
        qs  = '0;
        nc  = CLASS_UNKNOWN;
        case (state_reg)
            B_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (&clr_reg)
                begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE:
            begin
                if (!empty)
                begin
                    pop        = 1'b1;
                    cur_next   = job;
                    rchg_next  = 1'b0;
                    rnew_next  = 1'b0;
                    rinv_next  = 1'b0;
                    roor_next  = !job.in_grid;
                    rcls_next  = CLASS_UNKNOWN;
                    rprob_next = '0;
                    wr_next    = 1'b0;
                    state_next = job.in_grid ? B_READ : B_OUT;
                end
            end
            B_READ:
            begin
                if (!ram_rdata[ENTRY_W-1])
                begin
                    rnew_next  = 1'b1;
                    rprob_next = cfg.init_p;
                    rcls_next  = CLASS_UNKNOWN;
                    wr_next    = 1'b1;
                    state_next = B_OUT;
                end
                else
                begin
                    p_next     = ram_rdata[PROB_W-1:0];
                    old_next   = class_t'(ram_rdata[PROB_W+1:PROB_W]);
                    state_next = B_MUL;
                end
            end
            B_MUL:
            begin
                num_next  = 32'(cur_reg.obs) * 32'(p_reg);
                prod_next = 34'(17'h10000 - 17'(cur_reg.obs))
                            * 34'(17'h10000 - 17'(p_reg));
                state_next = B_SUM;
            end
            B_SUM:
            begin
                den_next = 34'(num_reg) + prod_reg;
                x        = {num_reg, 16'b0} + 49'(den_next >> 1);
                rem_next = 34'(x[48:17]);
                xlo_next = x[16:0];
                q_next   = '0;
                cnt_next = '0;
                if (den_next == '0)
                begin
                    // keep the prior and flag it
                    rinv_next  = 1'b1;
                    rprob_next = p_reg;
                    rcls_next  = old_reg;
                    state_next = B_OUT;
                end
                else
                begin
                    state_next = B_DIV;
                end
            end
            B_DIV:
            begin
                rsh = {rem_reg[32:0], xlo_reg[16]};
                xlo_next = {xlo_reg[15:0], 1'b0};
                if (rsh >= den_reg)
                begin
                    rem_next = rsh - den_reg;
                    q_next   = {q_reg[15:0], 1'b1};
                end
                else
                begin
                    rem_next = rsh;
                    q_next   = {q_reg[15:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 5'd16)
                begin
                    qs = q_next[16] ? '1 : q_next[PROB_W-1:0];
                    nc = classify(qs, cfg.occ_thr, cfg.free_thr);
                    rprob_next = qs;
                    rcls_next  = nc;
                    rchg_next  = nc != old_reg;
                    wr_next    = 1'b1;
                    state_next = B_OUT;
                end
            end
            B_OUT:
            begin
                if (!ov_reg || out_ready)
                begin
                    ram_we     = wr_reg;
                    ov_next    = 1'b1;
                    ocls_next  = rcls_reg;
                    oprob_next = rprob_reg;
                    ochg_next  = rchg_reg;
                    onew_next  = rnew_reg;
                    ooor_next  = roor_reg;
                    oinv_next  = rinv_reg;
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end
endmodule

// File: hw/rtl/voxel_bayes_occupancy_update_unit.sv
// Flow: each input transaction runs the 24-step index divider and passes the queue; then an
// out-of-range item goes to the result, a new voxel takes the initial probability, and an
// update runs the 17-step posterior divider. The front takes a new point only after pushing
// the last one; a 4-entry queue between front and back absorbs output stalls.
// Reset: control and config registers return to reset values; then the voxel store is swept
// clear, one entry a cycle over all 32768 entries; no input transaction is taken meanwhile.
module voxel_bayes_occupancy_update_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // point_x[23:0], point_y[47:24], point_z[71:48], obs probability[87:72]
    input  logic [87:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // voxel_class[1:0], probability[17:2], class_changed[18], zero pad[23:19]
    output logic [23:0] m_axis_tdata,
    // newly_created[0], out_of_range[1], update_invalid[2]
    output logic [2:0]  m_axis_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import vbo_pkg::*;

    logic [PROB_W-1:0] occ_thr_reg, free_thr_reg, init_p_reg;
    logic [VSIZE_W-1:0] vsize_reg;
    reg_idx_t ridx;
    logic wr_en;
    job_t fjob, qjob;
    logic push, full, pop, empty, back_ok;
    back_cfg_t bcfg;
    logic [1:0] ocls;
    logic [PROB_W-1:0] oprob;
    logic ochg, onew, ooor, oinv;

    assign pready = 1'b1;
    assign ridx   = reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_thr_reg  <= 16'd45875;
            free_thr_reg <= 16'd19661;
            vsize_reg    <= 23'd256;
            init_p_reg   <= 16'd32768;
        end
        else if (wr_en)
        begin
            case (ridx)
                REG_OCC_THR:  occ_thr_reg  <= pwdata[PROB_W-1:0];
                REG_FREE_THR: free_thr_reg <= pwdata[PROB_W-1:0];
                REG_VSIZE:    vsize_reg    <= pwdata[VSIZE_W-1:0];
                REG_INIT_P:   init_p_reg   <= pwdata[PROB_W-1:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        case (ridx)
            REG_OCC_THR:  prdata = 32'(occ_thr_reg);
            REG_FREE_THR: prdata = 32'(free_thr_reg);
            REG_VSIZE:    prdata = 32'(vsize_reg);
            REG_INIT_P:   prdata = 32'(init_p_reg);
            default:      prdata = '0;
        endcase
    end

    assign bcfg.occ_thr  = occ_thr_reg;
    assign bcfg.free_thr = free_thr_reg;
    assign bcfg.init_p   = init_p_reg;

    vbo_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .enable   (back_ok),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .px       (s_axis_tdata[23:0]),
        .py       (s_axis_tdata[47:24]),
        .pz       (s_axis_tdata[71:48]),
        .obs      (s_axis_tdata[87:72]),
        .vsize    (vsize_reg),
        .push     (push),
        .job      (fjob),
        .full     (full)
    );

    vbo_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (fjob),
        .full  (full),
        .pop   (pop),
        .rdata (qjob),
        .empty (empty)
    );

    vbo_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (bcfg),
        .empty           (empty),
        .job             (qjob),
        .pop             (pop),
        .ready_for_items (back_ok),
        .out_valid       (m_axis_tvalid),
        .out_ready       (m_axis_tready),
        .out_class       (ocls),
        .out_prob        (oprob),
        .out_changed     (ochg),
        .out_new         (onew),
        .out_oor         (ooor),
        .out_inv         (oinv)
    );

    assign m_axis_tdata = {5'b0, ochg, oprob, ocls};
    assign m_axis_tuser = {oinv, ooor, onew};
endmodule

// File: hw/rtl/vbo_checker.sv
module vbo_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser
);
    import vbo_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped or changed while stalled");

    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> $onehot0(m_axis_tuser))
        else $error("more than one result flag set");

    a_oor: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[1] |->
            m_axis_tdata[17:2] == '0 && m_axis_tdata[1:0] == CLASS_UNKNOWN
            && !m_axis_tdata[18])
        else $error("out of range result not neutral");

    a_new: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |->
            m_axis_tdata[1:0] == CLASS_UNKNOWN && !m_axis_tdata[18])
        else $error("new voxel result has wrong class");
endmodule

bind voxel_bayes_occupancy_update_unit vbo_checker u_vbo_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
